### hdl/frl_pkg.sv
`timescale 1ns / 1ps
package frl_pkg;

  // Frame layout
  localparam int unsigned EthHdrLen    = 14;
  localparam int unsigned ArpBodyLen   = 28;
  localparam int unsigned ArpTipOffset = 24;
  localparam int unsigned IpHdrLen     = 20;
  localparam int unsigned IpDstOffset  = 16;
  localparam logic [15:0] TypeArp      = 16'h0806;
  localparam logic [15:0] TypeIpv4     = 16'h0800;

  // Default sizing
  localparam int unsigned TableEntriesDefault = 256;
  localparam int unsigned PortBitsDefault     = 16;
  localparam int unsigned CmdDepth            = 4;

  typedef enum logic [1:0] {
    WS_OK     = 2'd0,
    WS_FULL   = 2'd1,
    WS_ABSENT = 2'd2
  } write_status_e;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_SCAN,
    BK_WAIT,
    BK_DONE
  } back_st_e;

  typedef struct packed {
    logic        mode;
    logic [7:0]  frame_byte;
    logic        frame_last;
    logic [31:0] route_key;
    logic [15:0] route_port;
    logic        route_keep;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic        verdict;
    logic [15:0] out_port;
    logic [1:0]  write_status;
  } out_item_t;

  // Command handed from the parser to the table engine
  typedef struct packed {
    logic        is_write;
    logic        probe;
    logic        keep;
    logic [31:0] key;
    logic [15:0] port;
  } cmd_t;

endpackage

### hdl/frame_route_lookup_forwarder.sv
`timescale 1ns / 1ps
// Exact-match IPv4/ARP destination forwarder.
// Input queue side: push/full carry one beat per cycle, either a frame byte
// (with a last-byte mark) or a route table write. Frame bytes are parsed as
// they arrive; the last byte hands a lookup command to a 4-deep command queue.
// Output queue side: empty/pop; the oldest result sits on out_item_o while
// empty is low. A frame gives a verdict (redirect plus port, or pass) and a
// route write gives an acknowledgement with status.
// Frame bytes without the last mark are taken one per cycle while full is
// low. Each lookup or route write scans the whole table through one memory
// read port in the table engine; a frame that cannot match (short or other
// ethertype) skips the scan there. Bytes keep flowing until the command
// queue fills.
// After reset the table is cleared one entry per cycle, with full held high.
// When the receiver stalls, the result stays in the output register, the
// engine waits, the queue fills and full rises.
module frame_route_lookup_forwarder #(
  parameter int unsigned TABLE_ENTRIES = frl_pkg::TableEntriesDefault,
  parameter int unsigned PORT_BITS     = frl_pkg::PortBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  frl_pkg::in_item_t  in_item_i,
  output logic               empty,
  input  logic               pop,
  output frl_pkg::out_item_t out_item_o
);
  import frl_pkg::*;

  logic acc, cmd_push, cmd_full, cmd_pop, cmd_empty, clearing;
  cmd_t cmd_in, cmd_out;

  assign full = cmd_full || clearing;
  assign acc  = push && !full;

  frl_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (acc),
    .item_i     (in_item_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  frl_cmd_fifo #(
    .DEPTH (CmdDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .data_o  (cmd_out)
  );

  frl_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .PORT_BITS     (PORT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .clearing_o  (clearing),
    .empty_o     (empty),
    .pop_i       (pop),
    .out_item_o  (out_item_o)
  );

endmodule

### hdl/frl_front.sv
`timescale 1ns / 1ps
module frl_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              acc_i,
  input  frl_pkg::in_item_t item_i,
  output logic              cmd_push_o,
  output frl_pkg::cmd_t     cmd_o
);
  import frl_pkg::*;

  localparam logic [15:0] ArpKeyStart = 16'(EthHdrLen + ArpTipOffset);
  localparam logic [15:0] IpKeyStart  = 16'(EthHdrLen + IpDstOffset);
  localparam logic [15:0] ArpMinLen   = 16'(EthHdrLen + ArpBodyLen);
  localparam logic [15:0] IpMinLen    = 16'(EthHdrLen + IpHdrLen);

  logic [15:0] pos_q, pos_d;
  logic [15:0] et_q, et_d;
  logic [31:0] lk_q, lk_d;
  logic [15:0] et_new, pos_new, key_start;
  logic [31:0] lk_new;
  logic        has_key, probe;

  // Parse one beat
  always_comb begin
    et_new = et_q;
    if (pos_q == 16'd12 || pos_q == 16'd13) begin
      et_new = {et_q[7:0], item_i.frame_byte};
    end
    has_key   = 1'b0;
    key_start = 16'd0;
    if (et_new == TypeArp && pos_q >= 16'(EthHdrLen)) begin
      has_key   = 1'b1;
      key_start = ArpKeyStart;
    end else if (et_new == TypeIpv4 && pos_q >= 16'(EthHdrLen)) begin
      has_key   = 1'b1;
      key_start = IpKeyStart;
    end
    lk_new = lk_q;
    if (has_key && pos_q >= key_start && pos_q < key_start + 16'd4) begin
      lk_new = {lk_q[23:0], item_i.frame_byte};
    end
    pos_new = (pos_q == 16'hFFFF) ? pos_q : pos_q + 16'd1;
    probe   = (et_new == TypeArp && pos_new >= ArpMinLen) ||
              (et_new == TypeIpv4 && pos_new >= IpMinLen);

    pos_d      = pos_q;
    et_d       = et_q;
    lk_d       = lk_q;
    cmd_push_o = 1'b0;
    cmd_o      = '0;
    if (acc_i) begin
      if (item_i.mode) begin
        cmd_push_o     = 1'b1;
        cmd_o.is_write = 1'b1;
        cmd_o.keep     = item_i.route_keep;
        cmd_o.key      = item_i.route_key;
        cmd_o.port     = item_i.route_port;
      end else if (item_i.frame_last) begin
        cmd_push_o  = 1'b1;
        cmd_o.probe = probe;
        cmd_o.key   = lk_new;
        pos_d       = '0;
        et_d        = '0;
        lk_d        = '0;
      end else begin
        pos_d = pos_new;
        et_d  = et_new;
        lk_d  = lk_new;
      end
    end
  end

  // Hold frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      et_q  <= '0;
      lk_q  <= '0;
    end else begin
      pos_q <= pos_d;
      et_q  <= et_d;
      lk_q  <= lk_d;
    end
  end

endmodule

### hdl/frl_cmd_fifo.sv
`timescale 1ns / 1ps
module frl_cmd_fifo #(
  parameter int unsigned DEPTH = frl_pkg::CmdDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  frl_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output frl_pkg::cmd_t data_o
);
  import frl_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PtrLast = PW'(DEPTH - 1);

  cmd_t          slots_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = slots_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Store a beat
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_q] <= data_i;
    end
  end

  // Advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrLast) ? '0 : wr_q + PW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrLast) ? '0 : rd_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

### hdl/frl_back.sv
`timescale 1ns / 1ps
module frl_back #(
  parameter int unsigned TABLE_ENTRIES = frl_pkg::TableEntriesDefault,
  parameter int unsigned PORT_BITS     = frl_pkg::PortBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_empty_i,
  input  frl_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  output logic               clearing_o,
  output logic               empty_o,
  input  logic               pop_i,
  output frl_pkg::out_item_t out_item_o
);
  import frl_pkg::*;

  localparam int unsigned IW = $clog2(TABLE_ENTRIES);
  localparam int unsigned EW = 1 + 32 + PORT_BITS;
  localparam logic [IW-1:0] IdxLast = IW'(TABLE_ENTRIES - 1);

  // Entry layout: {valid, address, port}
  logic [EW-1:0] mem [TABLE_ENTRIES];
  logic [EW-1:0] rd_q;
  logic          mem_we;
  logic [IW-1:0] mem_wa;
  logic [EW-1:0] mem_wd;

  back_st_e       st_q, st_d;
  logic [IW-1:0]  idx_q, idx_d;
  cmd_t           cmd_q, cmd_d;
  logic           chk_q;
  logic [IW-1:0]  chk_idx_q;
  logic           hit_q, hit_d, free_q, free_d;
  logic [IW-1:0]  hit_idx_q, hit_idx_d, free_idx_q, free_idx_d;
  logic [PORT_BITS-1:0] hit_port_q, hit_port_d;
  out_item_t      out_q, out_d;
  logic           out_v_q, out_push, out_free;
  logic           rd_valid;
  logic [31:0]    rd_addr;
  logic [PORT_BITS-1:0] rd_port, new_port;

  assign rd_valid   = rd_q[EW-1];
  assign rd_addr    = rd_q[EW-2 -: 32];
  assign rd_port    = rd_q[PORT_BITS-1:0];
  assign new_port   = PORT_BITS'(cmd_q.port);
  assign out_free   = !out_v_q || pop_i;
  assign empty_o    = !out_v_q;
  assign out_item_o = out_q;
  assign clearing_o = (st_q == BK_CLEAR);

  // Table memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[idx_q];
  end

  // Sequence clear, scan and update
  always_comb begin
    st_d       = st_q;
    idx_d      = idx_q;
    cmd_d      = cmd_q;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    hit_port_d = hit_port_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    cmd_pop_o  = 1'b0;
    mem_we     = 1'b0;
    mem_wa     = idx_q;
    mem_wd     = '0;
    out_push   = 1'b0;
    out_d      = out_q;

    // Compare the entry read last cycle
    if (chk_q) begin
      if (rd_valid && rd_addr == cmd_q.key && !hit_q) begin
        hit_d      = 1'b1;
        hit_idx_d  = chk_idx_q;
        hit_port_d = rd_port;
      end
      if (!rd_valid && !free_q) begin
        free_d     = 1'b1;
        free_idx_d = chk_idx_q;
      end
    end

    unique case (st_q)
      BK_CLEAR: begin
        mem_we = 1'b1;
        if (idx_q == IdxLast) begin
          st_d  = BK_IDLE;
          idx_d = '0;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end
      BK_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          hit_d     = 1'b0;
          free_d    = 1'b0;
          idx_d     = '0;
          st_d      = (cmd_i.is_write || cmd_i.probe) ? BK_SCAN : BK_DONE;
        end
      end
      BK_SCAN: begin
        if (idx_q == IdxLast) begin
          st_d = BK_WAIT;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end
      BK_WAIT: begin
        st_d = BK_DONE;
      end
      BK_DONE: begin
        if (out_free) begin
          out_push = 1'b1;
          out_d    = '0;
          st_d     = BK_IDLE;
          idx_d    = '0;
          if (cmd_q.is_write) begin
            out_d.result_kind  = 1'b1;
            out_d.write_status = WS_OK;
            mem_wd = {1'b1, cmd_q.key, new_port};
            if (cmd_q.keep) begin
              if (hit_q) begin
                mem_we = 1'b1;
                mem_wa = hit_idx_q;
              end else if (free_q) begin
                mem_we = 1'b1;
                mem_wa = free_idx_q;
              end else begin
                out_d.write_status = WS_FULL;
              end
            end else begin
              if (hit_q) begin
                mem_we = 1'b1;
                mem_wa = hit_idx_q;
                mem_wd = '0;
              end else begin
                out_d.write_status = WS_ABSENT;
              end
            end
          end else if (cmd_q.probe && hit_q) begin
            out_d.verdict  = 1'b1;
            out_d.out_port = 16'(hit_port_q);
          end
        end
      end
      default: st_d = BK_IDLE;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= BK_CLEAR;
      idx_q   <= '0;
      chk_q   <= 1'b0;
      hit_q   <= 1'b0;
      free_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      idx_q  <= idx_d;
      chk_q  <= (st_q == BK_SCAN);
      hit_q  <= hit_d;
      free_q <= free_d;
      if (out_push) begin
        out_v_q <= 1'b1;
      end else if (pop_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    chk_idx_q  <= idx_q;
    hit_idx_q  <= hit_idx_d;
    hit_port_q <= hit_port_d;
    free_idx_q <= free_idx_d;
    out_q      <= out_d;
  end

  a_clear_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != BK_CLEAR |=> st_q != BK_CLEAR)
    else $error("table clear restarted");

  a_push_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push |-> st_q == BK_DONE && out_free)
    else $error("result loaded outside completion");

  a_check_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == BK_WAIT |-> chk_q && $past(st_q) == BK_SCAN)
    else $error("last entry not compared");

  a_hit_free_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == BK_DONE && hit_q && free_q) |-> hit_idx_q != free_idx_q)
    else $error("entry both matched and free");

endmodule
